@@ rtl/core/tnp_pkg.sv @@
package tnp_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MAX   = 2'd3;

    // Saturation values
    localparam logic [VALUE_W-1:0] VAL_ZERO     = '0;
    localparam logic [VALUE_W-1:0] VAL_ALL_ONES = '1;
    localparam logic [VALUE_W-1:0] VAL_TOP_BIT  = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] VAL_POS_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};

    // Base-256 lead bytes
    localparam logic [BYTE_W-1:0] B256_POS = 8'h80;
    localparam logic [BYTE_W-1:0] B256_NEG = 8'hFF;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN = 8'h37;

    // One octal digit carries three bits (radix 010)
    localparam int OCT_DIGIT_W = 3;

    // Finished field, before the range check
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } fin_t;

endpackage

@@ rtl/core/tnp_parse.sv @@
module tnp_parse (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tnp_pkg::BYTE_W-1:0]   in_byte,
    input  logic                         in_last,
    input  logic                         signed_mode,
    output logic                         fin_valid,
    input  logic                         fin_ready,
    output tnp_pkg::fin_t                fin
);
    import tnp_pkg::*;

    typedef enum logic [1:0] {PH_FIRST, PH_LEAD, PH_DIGITS, PH_TRAIL} phase_t;

    logic [VALUE_W-1:0]  acc_reg, acc_next;
    phase_t              phase_reg, phase_next;
    logic                bin_reg, bin_next;
    logic                neg_reg, neg_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic                fin_valid_reg;
    fin_t                fin_reg, fin_next;

    logic                accept;
    logic                is_first, is_b256, is_space, is_nul, is_digit;
    phase_t              oct_p_in, oct_p, oct_eff;
    logic [VALUE_W-1:0]  oct_a_in, oct_a, bin_a;
    logic [STATUS_W-1:0] oct_e_in, oct_e, bin_e, fin_err;

    assign in_ready = !fin_valid_reg || fin_ready;
    assign accept   = in_valid && in_ready;

    // Byte classes
    assign is_first = (phase_reg == PH_FIRST);
    assign is_b256  = (in_byte == B256_POS) || (in_byte == B256_NEG);
    assign is_space = (in_byte == CH_SPACE);
    assign is_nul   = (in_byte == CH_NUL);
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);

    // Octal step; a non-binary first byte starts from a cleared lead phase
    always_comb begin
        oct_p_in = is_first ? PH_LEAD : phase_reg;
        oct_a_in = is_first ? VAL_ZERO : acc_reg;
        oct_e_in = is_first ? ST_OK : err_reg;
        oct_p    = oct_p_in;
        oct_a    = oct_a_in;
        oct_e    = oct_e_in;
        oct_eff  = oct_p_in;
        if (oct_e_in == ST_OK) begin
            if (oct_p_in == PH_LEAD && !is_space) begin
                oct_eff = PH_DIGITS;
            end
            oct_p = oct_eff;
            case (oct_eff)
                PH_LEAD: ;
                PH_DIGITS: begin
                    if (is_nul || is_space) begin
                        oct_p = PH_TRAIL;
                    end else if (!is_digit) begin
                        oct_e = ST_RANGE;
                    end else begin
                        oct_a = {oct_a_in[VALUE_W-OCT_DIGIT_W-1:0], in_byte[OCT_DIGIT_W-1:0]};
                    end
                end
                default: begin
                    if (!(is_nul || is_space)) begin
                        oct_e = ST_INVALID;
                    end
                end
            endcase
        end
    end

    // Base-256 step: the byte shifted out must match the sign fill
    assign bin_e = (acc_reg[VALUE_W-1 -: BYTE_W] != {BYTE_W{neg_reg}}) ? ST_RANGE : err_reg;
    assign bin_a = {acc_reg[VALUE_W-BYTE_W-1:0], in_byte};

    // Parse state update
    always_comb begin
        acc_next   = acc_reg;
        phase_next = phase_reg;
        bin_next   = bin_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        if (is_first && is_b256) begin
            bin_next   = 1'b1;
            neg_next   = (in_byte == B256_NEG);
            acc_next   = {VALUE_W{neg_next}};
            phase_next = PH_DIGITS;
            err_next   = ST_OK;
        end else if (is_first || !bin_reg) begin
            bin_next   = 1'b0;
            neg_next   = is_first ? 1'b0 : neg_reg;
            acc_next   = oct_a;
            phase_next = oct_p;
            err_next   = oct_e;
        end else begin
            acc_next = bin_a;
            err_next = bin_e;
        end
    end

    // Field close: final checks and error saturation
    always_comb begin
        fin_err = err_next;
        if (bin_next) begin
            if (acc_next[VALUE_W-1] != neg_next) begin
                fin_err = ST_RANGE;
            end
        end else if (phase_next == PH_LEAD && err_next == ST_OK) begin
            fin_err = ST_INVALID;
        end
        fin_next.status = fin_err;
        fin_next.value  = acc_next;
        if (fin_err != ST_OK) begin
            if (!bin_next) begin
                fin_next.value = VAL_ZERO;
            end else if (signed_mode) begin
                fin_next.value = neg_next ? VAL_TOP_BIT : VAL_POS_MAX;
            end else begin
                fin_next.value = neg_next ? VAL_ZERO : VAL_ALL_ONES;
            end
        end
    end

    // State and finished-field register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= VAL_ZERO;
            phase_reg     <= PH_FIRST;
            bin_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            err_reg       <= ST_OK;
            fin_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (in_last) begin
                    acc_reg   <= VAL_ZERO;
                    phase_reg <= PH_FIRST;
                    bin_reg   <= 1'b0;
                    neg_reg   <= 1'b0;
                    err_reg   <= ST_OK;
                end else begin
                    acc_reg   <= acc_next;
                    phase_reg <= phase_next;
                    bin_reg   <= bin_next;
                    neg_reg   <= neg_next;
                    err_reg   <= err_next;
                end
            end
            if (accept && in_last) begin
                fin_valid_reg <= 1'b1;
            end else if (fin_ready) begin
                fin_valid_reg <= 1'b0;
            end
        end
        if (accept && in_last) begin
            fin_reg <= fin_next;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

@@ rtl/core/tnp_range.sv @@
module tnp_range (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fin_valid,
    output logic                           fin_ready,
    input  tnp_pkg::fin_t                  fin,
    input  logic                           signed_mode,
    input  logic [tnp_pkg::VALUE_W-1:0]    unsigned_max,
    input  logic signed [tnp_pkg::VALUE_W-1:0] signed_min,
    input  logic signed [tnp_pkg::VALUE_W-1:0] signed_max,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tnp_pkg::VALUE_W-1:0]    m_value,
    output logic [tnp_pkg::STATUS_W-1:0]   m_status
);
    import tnp_pkg::*;

    logic                m_valid_reg;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                below_min, above_max, above_umax;

    assign fin_ready = !m_valid_reg || m_ready;

    // Range compares run in parallel
    assign below_min  = $signed(fin.value) < signed_min;
    assign above_max  = signed_max < $signed(fin.value);
    assign above_umax = fin.value > unsigned_max;

    // A failed range check overrides the parse status
    always_comb begin
        value_next  = fin.value;
        status_next = fin.status;
        if (signed_mode) begin
            if (below_min) begin
                value_next  = VAL_TOP_BIT;
                status_next = ST_RANGE;
            end else if (above_max) begin
                value_next  = VAL_POS_MAX;
                status_next = ST_RANGE;
            end
        end else if (above_umax) begin
            value_next  = VAL_ALL_ONES;
            status_next = ST_RANGE;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            m_valid_reg <= fin_valid;
        end
        if (fin_ready && fin_valid) begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = value_reg;
    assign m_status = status_reg;

endmodule

@@ rtl/core/tar_numeric_field_parser.sv @@
// Tar header numeric field parser.
// Input channel (s_valid/s_ready): one field byte per beat, s_last_byte marks
// the final byte. A lead byte of 0x80 or 0xFF selects base-256, anything
// else octal. Only the last beat of a field yields a result beat.
// Result channel (m_valid/m_ready): m_value and m_status (0 ok, 1 invalid,
// 2 out of range), after the unsigned or signed range check.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
// (0 signed_mode, 1 unsigned_max, 2 signed_min, 3 signed_max); write only
// while no field is in flight.
// Throughput: one byte per cycle while s_ready is high. A result passes two
// register stages after its last byte is taken: the parse register, then the
// range-check output register.
// Reset clears the parse state and the valid flags of both pipeline registers
// and restores the register defaults (unsigned mode, full 64-bit ranges).
// When m_ready is low the result holds; s_ready stays high until both the
// finished-field register and the output register are full.
module tar_numeric_field_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tnp_pkg::BYTE_W-1:0]       s_field_byte,
    input  logic                             s_last_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tnp_pkg::VALUE_W-1:0]      m_value,
    output logic [tnp_pkg::STATUS_W-1:0]     m_status,
    input  logic                             cfg_wr_en,
    input  logic [tnp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tnp_pkg::VALUE_W-1:0]      cfg_wr_data
);
    import tnp_pkg::*;

    logic                       signed_mode_reg;
    logic [VALUE_W-1:0]         unsigned_max_reg;
    logic signed [VALUE_W-1:0]  signed_min_reg;
    logic signed [VALUE_W-1:0]  signed_max_reg;

    logic fin_valid, fin_ready;
    fin_t fin;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg  <= 1'b0;
            unsigned_max_reg <= VAL_ALL_ONES;
            signed_min_reg   <= $signed(VAL_TOP_BIT);
            signed_max_reg   <= $signed(VAL_POS_MAX);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SIGNED_MODE:  signed_mode_reg  <= cfg_wr_data[0];
                REG_UNSIGNED_MAX: unsigned_max_reg <= cfg_wr_data;
                REG_SIGNED_MIN:   signed_min_reg   <= $signed(cfg_wr_data);
                REG_SIGNED_MAX:   signed_max_reg   <= $signed(cfg_wr_data);
                default: ;
            endcase
        end
    end

    // Byte parser
    tnp_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_byte     (s_field_byte),
        .in_last     (s_last_byte),
        .signed_mode (signed_mode_reg),
        .fin_valid   (fin_valid),
        .fin_ready   (fin_ready),
        .fin         (fin)
    );

    // Range check and output register
    tnp_range u_range (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fin_valid    (fin_valid),
        .fin_ready    (fin_ready),
        .fin          (fin),
        .signed_mode  (signed_mode_reg),
        .unsigned_max (unsigned_max_reg),
        .signed_min   (signed_min_reg),
        .signed_max   (signed_max_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_status     (m_status)
    );

endmodule

@@ rtl/core/tnp_checker.sv @@
module tnp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [tnp_pkg::VALUE_W-1:0]    m_value,
    input logic [tnp_pkg::STATUS_W-1:0]   m_status
);
    import tnp_pkg::*;

    // Nothing is offered in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat right after reset");

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("stalled result beat changed");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_INVALID || m_status == ST_RANGE))
        else $error("undefined status code");

    // An invalid field always reports zero
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_INVALID |-> m_value == VAL_ZERO)
        else $error("invalid field with nonzero value");

    // A range error reports zero or one of the saturation values
    a_range_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_RANGE |->
            (m_value == VAL_ZERO || m_value == VAL_ALL_ONES ||
             m_value == VAL_TOP_BIT || m_value == VAL_POS_MAX))
        else $error("range error with unsaturated value");

endmodule

bind tar_numeric_field_parser tnp_checker u_tnp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_value  (m_value),
    .m_status (m_status)
);

@@ sim/tb_tar_numeric_field_parser.sv @@
module tb_tar_numeric_field_parser;
    import tnp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_TAIL  = 4;
    localparam int PHASE_BEATS = 154;

    // Parse phase of the field scanner
    typedef enum logic [1:0] {
        SCAN_FIRST,
        SCAN_LEAD,
        SCAN_DIGITS,
        SCAN_TRAIL
    } scan_t;

    // Kinds of generated fields
    typedef enum int {
        FK_OCTAL,
        FK_B256,
        FK_BLANK,
        FK_BAD_DIGIT,
        FK_JUNK,
        FK_NOISE
    } field_kind_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        int unsigned       gap;
    } field_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } parsed_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_field_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [VALUE_W-1:0]   m_value;
    logic [STATUS_W-1:0]  m_status;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VALUE_W-1:0]   cfg_wr_data = '0;

    tar_numeric_field_parser uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_field_byte(s_field_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Register shadow
    logic               sh_signed = 1'b0;
    logic [VALUE_W-1:0] sh_umax = VAL_ALL_ONES;
    logic [VALUE_W-1:0] sh_smin = VAL_TOP_BIT;
    logic [VALUE_W-1:0] sh_smax = VAL_POS_MAX;

    // Scanner state
    logic [VALUE_W-1:0]  acc = '0;
    scan_t               scan = SCAN_FIRST;
    logic                b256 = 1'b0;
    logic                neg = 1'b0;
    logic [STATUS_W-1:0] err = ST_OK;

    field_beat_t beat_q[$];
    parsed_t     parsed_q[$];
    int          errors = 0;
    int          beats_queued = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_req = 0;
    int          holds_served = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;

    // Octal character: leading spaces, digits, then NUL/space only
    task automatic octal_char(input logic [BYTE_W-1:0] b);
        if (err != ST_OK) return;
        if (scan == SCAN_LEAD) begin
            if (b == CH_SPACE) return;
            scan = SCAN_DIGITS;
        end
        if (scan == SCAN_DIGITS) begin
            if (b == CH_NUL || b == CH_SPACE) begin
                scan = SCAN_TRAIL;
            end else if (b < CH_ZERO || b > CH_SEVEN) begin
                err = ST_RANGE;
            end else begin
                acc = {acc[VALUE_W-OCT_DIGIT_W-1:0], b[OCT_DIGIT_W-1:0]};
            end
        end else if (b != CH_NUL && b != CH_SPACE) begin
            err = ST_INVALID;
        end
    endtask

    // Base-256 byte: the byte shifted out must be the sign fill
    task automatic b256_char(input logic [BYTE_W-1:0] b);
        if (acc[VALUE_W-1 -: BYTE_W] != {BYTE_W{neg}}) err = ST_RANGE;
        acc = {acc[VALUE_W-BYTE_W-1:0], b};
    endtask

    // Advance the scanner by one accepted beat; a last beat yields a result
    task automatic parse_field_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [VALUE_W-1:0]  v;
        logic [STATUS_W-1:0] st;
        parsed_t             res;
        if (scan == SCAN_FIRST) begin
            if (b == B256_POS || b == B256_NEG) begin
                b256 = 1'b1;
                neg  = (b == B256_NEG);
                acc  = {VALUE_W{neg}};
                scan = SCAN_DIGITS;
                b256_char({BYTE_W{neg}});
            end else begin
                acc  = '0;
                scan = SCAN_LEAD;
                octal_char(b);
            end
        end else if (b256) begin
            b256_char(b);
        end else begin
            octal_char(b);
        end
        if (last) begin
            if (b256) begin
                if (acc[VALUE_W-1] != neg) err = ST_RANGE;
            end else if (scan == SCAN_LEAD && err == ST_OK) begin
                err = ST_INVALID;
            end
            v  = acc;
            st = err;
            if (st != ST_OK) begin
                if (!b256) v = VAL_ZERO;
                else if (sh_signed) v = neg ? VAL_TOP_BIT : VAL_POS_MAX;
                else v = neg ? VAL_ZERO : VAL_ALL_ONES;
            end
            // a failed range check overrides any earlier status
            if (sh_signed) begin
                if ($signed(v) < $signed(sh_smin)) begin
                    v  = VAL_TOP_BIT;
                    st = ST_RANGE;
                end else if ($signed(sh_smax) < $signed(v)) begin
                    v  = VAL_POS_MAX;
                    st = ST_RANGE;
                end
            end else if (v > sh_umax) begin
                v  = VAL_ALL_ONES;
                st = ST_RANGE;
            end
            res.value  = v;
            res.status = st;
            parsed_q.push_back(res);
            acc  = '0;
            scan = SCAN_FIRST;
            b256 = 1'b0;
            neg  = 1'b0;
            err  = ST_OK;
        end
    endtask

    // Monitor: check result beats, then feed accepted input beats to the scanner
    always @(posedge aclk) begin
        parsed_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (parsed_q.size() == 0) begin
                    $display("%0t: unexpected result value %h status %0d",
                             $time, m_value, m_status);
                    errors++;
                end else begin
                    want = parsed_q.pop_front();
                    if (m_value !== want.value) begin
                        $display("%0t: value mismatch: expected %h, got %h",
                                 $time, want.value, m_value);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_status);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) parse_field_byte(s_field_byte, s_last_byte);
        end
        in_taken  <= aresetn && s_valid && s_ready;
        out_taken <= aresetn && m_valid && m_ready;
    end

    // Driver: one beat at a time from beat_q, with its own idle gap
    field_beat_t next_beat;
    bit          have_next = 1'b0;
    int unsigned gap_left = 0;

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (!have_next && beat_q.size() != 0) begin
                next_beat = beat_q.pop_front();
                have_next = 1'b1;
                gap_left  = next_beat.gap;
            end
            if (have_next && gap_left == 0) begin
                s_valid      <= 1'b1;
                s_field_byte <= next_beat.data;
                s_last_byte  <= next_beat.last;
                have_next     = 1'b0;
            end else begin
                s_valid <= 1'b0;
                if (have_next) gap_left--;
            end
        end
    end

    // Receiver: random stall per result when rx_idle_on, plus a long hold-off on request
    int unsigned ready_wait = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (holds_served < hold_req) begin
                ready_wait = LONG_HOLD;
                holds_served++;
            end else if (out_taken) begin
                ready_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (ready_wait > 0) begin
                ready_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_beat(input logic [BYTE_W-1:0] d, input logic last);
        field_beat_t bt;
        bt.data = d;
        bt.last = last;
        bt.gap  = tx_idle_on ? $urandom_range(0, 9) : 0;
        beat_q.push_back(bt);
        beats_queued++;
    endtask

    task automatic push_field(input logic [BYTE_W-1:0] fb[$]);
        int i;
        for (i = 0; i < fb.size(); i++) push_beat(fb[i], i == fb.size() - 1);
    endtask

    // Build one field of the given kind and queue it
    task automatic queue_field(input field_kind_t kind);
        logic [BYTE_W-1:0] fb[$];
        logic [BYTE_W-1:0] bad;
        logic              sgn;
        int                n, lead, i;
        case (kind)
            FK_B256: begin
                sgn = 1'($urandom_range(0, 1));
                fb.push_back(sgn ? B256_NEG : B256_POS);
                n = ($urandom_range(0, 99) < 50) ? $urandom_range(0, 4) : $urandom_range(5, 11);
                for (i = 0; i < n; i++) begin
                    // bytes that get shifted out are mostly the sign fill
                    if (n - i > 8 && $urandom_range(0, 99) < 85)
                        fb.push_back({BYTE_W{sgn}});
                    else if (n - i == 8 && $urandom_range(0, 99) < 70)
                        fb.push_back({sgn, 7'($urandom)});
                    else
                        fb.push_back(8'($urandom));
                end
            end
            FK_BLANK: begin
                repeat ($urandom_range(1, 4)) fb.push_back(CH_SPACE);
            end
            FK_NOISE: begin
                repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
            end
            default: begin
                lead = $urandom_range(0, 3);
                repeat (lead) fb.push_back(CH_SPACE);
                n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 22);
                repeat (n) fb.push_back({5'b00110, 3'($urandom)});
                if (kind == FK_BAD_DIGIT) begin
                    do bad = 8'($urandom);
                    while ((bad >= CH_ZERO && bad <= CH_SEVEN) || bad == CH_NUL ||
                           bad == CH_SPACE);
                    fb[$urandom_range(lead, lead + n - 1)] = bad;
                end
                repeat ((kind == FK_JUNK) ? $urandom_range(1, 3) : $urandom_range(0, 3))
                    fb.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NUL);
                if (kind == FK_JUNK) begin
                    do bad = 8'($urandom);
                    while (bad == CH_NUL || bad == CH_SPACE);
                    fb.push_back(bad);
                    repeat ($urandom_range(0, 2)) fb.push_back(8'($urandom));
                end
            end
        endcase
        push_field(fb);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_SIGNED_MODE:  sh_signed = data[0];
            REG_UNSIGNED_MAX: sh_umax = data;
            REG_SIGNED_MIN:   sh_smin = data;
            REG_SIGNED_MAX:   sh_smax = data;
            default: ;
        endcase
    endtask

    // Wait until every queued beat is taken and every result has arrived
    task automatic drain_all();
        while (beat_q.size() != 0 || have_next || s_valid || parsed_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    // One configuration setting followed by random fields
    task automatic run_phase(input logic mode, input logic [VALUE_W-1:0] umax,
                             input logic [VALUE_W-1:0] smin, input logic [VALUE_W-1:0] smax,
                             input bit tx_idle, input bit rx_idle, input bit long_hold);
        int start, r;
        field_kind_t kind;
        write_reg(REG_SIGNED_MODE, {63'($urandom) << 32 | 63'($urandom), mode});
        write_reg(REG_UNSIGNED_MAX, umax);
        write_reg(REG_SIGNED_MIN, smin);
        write_reg(REG_SIGNED_MAX, smax);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        if (long_hold) hold_req++;
        start = beats_queued;
        while (beats_queued - start < PHASE_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 35) kind = FK_OCTAL;
            else if (r < 65) kind = FK_B256;
            else if (r < 70) kind = FK_BLANK;
            else if (r < 80) kind = FK_BAD_DIGIT;
            else if (r < 90) kind = FK_JUNK;
            else kind = FK_NOISE;
            queue_field(kind);
        end
        drain_all();
    endtask

    int cycles;

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0] fb[$];
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed fields under reset defaults
        fb = '{CH_SEVEN};                          push_field(fb);
        fb = '{CH_SPACE};                          push_field(fb);
        fb = '{B256_POS};                          push_field(fb);
        fb = '{B256_NEG};                          push_field(fb);
        fb = '{CH_SPACE, 8'h31, CH_SEVEN, CH_NUL}; push_field(fb);
        fb = '{8'h38};                             push_field(fb);
        fb = '{CH_ZERO, CH_NUL, 8'h41};            push_field(fb);
        fb = '{B256_POS, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        push_field(fb);
        fb = '{B256_NEG, 8'h80};                   push_field(fb);
        drain_all();

        // Random phases over several register settings
        run_phase(1'b0, VAL_ALL_ONES, VAL_TOP_BIT, VAL_POS_MAX, 1'b1, 1'b1, 1'b0);
        run_phase(1'b0, VAL_ZERO, VAL_TOP_BIT, VAL_POS_MAX, 1'b0, 1'b0, 1'b0);
        run_phase(1'b0, 64'($urandom_range(0, 1 << 24)), VAL_ZERO, VAL_ZERO,
                  1'b1, 1'b0, 1'b0);
        run_phase(1'b1, VAL_ALL_ONES, VAL_TOP_BIT, VAL_POS_MAX, 1'b1, 1'b1, 1'b1);
        run_phase(1'b1, VAL_ZERO, VAL_ZERO, VAL_ZERO, 1'b0, 1'b1, 1'b0);
        run_phase(1'b1, VAL_ALL_ONES, 64'd0 - 64'($urandom_range(0, 1 << 24)),
                  64'($urandom_range(0, 1 << 24)), 1'b0, 1'b0, 1'b0);
        run_phase(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  1'b1, 1'b1, 1'b0);
        run_phase(1'b0, {$urandom, $urandom}, VAL_POS_MAX, VAL_TOP_BIT, 1'b1, 1'b1, 1'b0);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tnp_pkg.sv
rtl/core/tnp_parse.sv
rtl/core/tnp_range.sv
rtl/core/tar_numeric_field_parser.sv
rtl/core/tnp_checker.sv
sim/tb_tar_numeric_field_parser.sv
